[rtl/core/uniform_range_quantizer_core_assert.svh]
// Assertion helpers for the quantizer core RTL.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef UNIFORM_RANGE_QUANTIZER_CORE_ASSERT_SVH
`define UNIFORM_RANGE_QUANTIZER_CORE_ASSERT_SVH

// pre and post in the same cycle
`define URQ_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("quantizer check failed");

// post in the cycle after pre
`define URQ_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("quantizer check failed");

`endif

[rtl/core/urq_pkg.sv]
`default_nettype none

package urq_pkg;

  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_MAX_LEVELS  = 256;
  localparam int DEF_FRAC_BITS   = 8;

  localparam int FUNC_W     = 2;
  localparam int VALUE_W    = 24;
  localparam int LEVEL_W    = 8;
  localparam int STEP_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int LC_FIELD_W = 16;  // level_count bits kept from a write, before clamping

  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MEASURE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUANTIZE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_RANGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORCED_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORCED_HIGH = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LVL_MUL,
    ST_LVL_GO,
    ST_LVL_WAIT,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_VAL_MUL,
    ST_VAL_GO,
    ST_VAL_WAIT,
    ST_OUT
  } urq_state_e;

endpackage

`default_nettype wire

[rtl/core/urq_regs.sv]
`default_nettype none

// Config registers and running min/max; presents the active range.
module urq_regs
  import urq_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int MAX_LEVELS  = DEF_MAX_LEVELS,
  localparam int CFG_W = (SAMPLE_BITS > LC_FIELD_W) ? SAMPLE_BITS : LC_FIELD_W,
  localparam int LCW   = $clog2(MAX_LEVELS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  input  logic                          clear_i,
  input  logic                          measure_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] lo_o,
  output logic signed [SAMPLE_BITS-1:0] hi_o,
  output logic [LCW-1:0]                levels_o,
  output logic                          left_mode_o
);

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [LCW-1:0]                levels_q, levels_d;
  logic                          left_q, force_q;
  logic signed [SAMPLE_BITS-1:0] flo_q, fhi_q, seen_lo_q, seen_hi_q;
  logic [LC_FIELD_W-1:0]         lc_raw;

  // level count is clamped on write: zero acts as one, overrange saturates
  assign lc_raw = cfg_data_i[LC_FIELD_W-1:0];
  always_comb begin
    if (lc_raw == '0) begin
      levels_d = LCW'(1);
    end else if (lc_raw > LC_FIELD_W'(MAX_LEVELS)) begin
      levels_d = LCW'(MAX_LEVELS);
    end else begin
      levels_d = LCW'(lc_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q  <= LCW'(2);
      left_q    <= 1'b0;
      force_q   <= 1'b0;
      flo_q     <= '0;
      fhi_q     <= '0;
      seen_lo_q <= S_MAX;
      seen_hi_q <= S_MIN;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LEVEL_COUNT: levels_q <= levels_d;
          REG_LEFT_MODE:   left_q   <= cfg_data_i[0];
          REG_FORCE_RANGE: force_q  <= cfg_data_i[0];
          REG_FORCED_LOW:  flo_q    <= $signed(cfg_data_i[SAMPLE_BITS-1:0]);
          REG_FORCED_HIGH: fhi_q    <= $signed(cfg_data_i[SAMPLE_BITS-1:0]);
          default: ;
        endcase
      end
      if (clear_i) begin
        seen_lo_q <= S_MAX;
        seen_hi_q <= S_MIN;
      end else if (measure_i) begin
        if (sample_i < seen_lo_q) seen_lo_q <= sample_i;
        if (sample_i > seen_hi_q) seen_hi_q <= sample_i;
      end
    end
  end

  assign lo_o        = force_q ? flo_q : seen_lo_q;
  assign hi_o        = force_q ? fhi_q : seen_hi_q;
  assign levels_o    = levels_q;
  assign left_mode_o = left_q;

endmodule

`default_nettype wire

[rtl/core/urq_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Caller supplies the upper part of the dividend in rem_i (must be < den_i)
// and the remaining count_i dividend bits MSB-aligned in bits_i.
module urq_div
  import urq_pkg::*;
#(
  parameter int DEN_W = DEF_SAMPLE_BITS,
  parameter int Q_W   = DEF_SAMPLE_BITS + DEF_FRAC_BITS,
  localparam int CNT_W = $clog2(Q_W + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [Q_W-1:0]   bits_i,
  output logic             busy_o,
  output logic [Q_W-1:0]   quot_o
);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [Q_W-1:0]   quot_q;
  logic [DEN_W:0]   trial, diff;
  logic             fits;

  assign trial = {rem_q, quot_q[Q_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= count_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      rem_q  <= rem_i;
      quot_q <= bits_i;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot_q <= {quot_q[Q_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

[rtl/core/uniform_range_quantizer_core.sv]
// Uniform min/max quantizer for signed samples. An input transfer carries a
// function code and a sample: clear resets the measured range, measure folds
// the sample into the running min/max, and neither produces a result; code 3
// is dropped. Quantize uses the forced bounds (force_range=1) or the measured
// ones, picks level floor((x-lo)*L/(hi-lo)) clamped to 0..L-1 and returns
// value, level, step and an empty-range flag in one output transfer. A
// quantize keeps the input side busy until its result is loaded into the
// output register, including any wait for that register to free up. The
// work is done by the single restoring divider, which yields one quotient
// bit per cycle and runs up to three divisions per sample: the level
// division is skipped when the sample lies on or outside the range edges,
// and no division runs when the range is empty.
// in_ready_o is high only between quantize operations.
`default_nettype none

`include "uniform_range_quantizer_core_assert.svh"

module uniform_range_quantizer_core
  import urq_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int MAX_LEVELS  = DEF_MAX_LEVELS,
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  localparam int CFG_W = (SAMPLE_BITS > LC_FIELD_W) ? SAMPLE_BITS : LC_FIELD_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]              cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [FUNC_W-1:0]             func_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_W-1:0]     value_q8_o,
  output logic [LEVEL_W-1:0]            level_index_o,
  output logic [STEP_W-1:0]             step_q8_o,
  output logic                          range_empty_o
);

  localparam int S     = SAMPLE_BITS;
  localparam int F     = FRAC_BITS;
  localparam int LCW   = $clog2(MAX_LEVELS + 1);  // holds L itself
  localparam int LW    = $clog2(MAX_LEVELS);      // holds a level index
  localparam int KW    = LCW + 1;                 // 2L and 2r+1
  localparam int DEN_W = (S > KW) ? S : KW;
  localparam int Q_W   = (S + F > LW) ? S + F : LW;
  localparam int CNT_W = $clog2(Q_W + 1);
  localparam int PW    = S + KW;
  localparam int VW    = S + F + 1;
  localparam int OW    = (VW > VALUE_W) ? VW : VALUE_W;
  localparam int SW    = (Q_W > STEP_W) ? Q_W : STEP_W;
  localparam int LVW   = (LW > LEVEL_W) ? LW : LEVEL_W;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  urq_state_e state_q, state_d;
  logic       in_fire;

  assign cfg_ready_o = 1'b1;            // registers take a write in any cycle
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Range and config
  // ---------------------------------------------------------------------------
  logic signed [S-1:0] lo, hi;
  logic [LCW-1:0]      levels;
  logic                left_mode;

  urq_regs #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_LEVELS  (MAX_LEVELS)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .clear_i     (in_fire && (func_i == FUNC_CLEAR)),
    .measure_i   (in_fire && (func_i == FUNC_MEASURE)),
    .sample_i    (sample_i),
    .lo_o        (lo),
    .hi_o        (hi),
    .levels_o    (levels),
    .left_mode_o (left_mode)
  );

  // ---------------------------------------------------------------------------
  // Operand prep: range width, sample offset, position of x against the range
  // ---------------------------------------------------------------------------
  logic signed [S-1:0] x_q;
  logic [S-1:0]        dist_q, off_q;   // hi-lo and x-lo (the latter only when lo<x<hi)
  logic                empty_q, below_q, above_q;
  logic [LW-1:0]       lvl_q;
  logic [Q_W-1:0]      step_q;
  logic [PW-1:0]       prod_q;

  logic signed [S:0]   dist_w, off_w;
  logic [LCW-1:0]      levels_m1;

  assign dist_w    = (S+1)'(hi) - (S+1)'(lo);
  assign off_w     = (S+1)'(x_q) - (S+1)'(lo);
  assign levels_m1 = levels - LCW'(1);

  // ---------------------------------------------------------------------------
  // Shared multiplier: (x-lo)*L for the level, D*k for the value numerator
  // ---------------------------------------------------------------------------
  logic [S-1:0]  mul_a;
  logic [KW-1:0] mul_b, k_w;

  assign k_w   = left_mode ? KW'(lvl_q) : KW'({lvl_q, 1'b1});
  assign mul_a = (state_q == ST_LVL_MUL) ? off_q : dist_q;
  assign mul_b = (state_q == ST_LVL_MUL) ? KW'(levels) : k_w;

  // ---------------------------------------------------------------------------
  // Shared divider, loaded with a different operation in each GO state
  //   level: (x-lo)*L / D, LW bits
  //   step:  D*2^F / L,    S+F bits
  //   value: k*D*2^F / L (left) or / 2L (middle), S+F bits
  // ---------------------------------------------------------------------------
  logic             div_start, div_busy;
  logic [CNT_W-1:0] div_count;
  logic [DEN_W-1:0] div_den, div_rem;
  logic [Q_W-1:0]   div_bits, div_quot;

  always_comb begin
    div_start = 1'b0;
    div_count = '0;
    div_den   = '0;
    div_rem   = '0;
    div_bits  = '0;
    case (state_q)
      ST_LVL_GO: begin
        div_start = 1'b1;
        div_count = CNT_W'(LW);
        div_den   = DEN_W'(dist_q);
        div_rem   = DEN_W'(prod_q >> LW);
        div_bits  = Q_W'(prod_q[LW-1:0]) << (Q_W - LW);
      end
      ST_STEP_GO: begin
        div_start = 1'b1;
        div_count = CNT_W'(S + F);
        div_den   = DEN_W'(levels);
        div_bits  = Q_W'(dist_q) << (Q_W - S);
      end
      ST_VAL_GO: begin
        div_start = 1'b1;
        div_count = CNT_W'(S + F);
        div_den   = left_mode ? DEN_W'(levels) : DEN_W'({levels, 1'b0});
        div_rem   = DEN_W'(prod_q >> S);
        div_bits  = Q_W'(prod_q[S-1:0]) << (Q_W - S);
      end
      default: ;
    endcase
  end

  urq_div #(
    .DEN_W (DEN_W),
    .Q_W   (Q_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .count_i (div_count),
    .den_i   (div_den),
    .rem_i   (div_rem),
    .bits_i  (div_bits),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_valid_q, out_load;

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (func_i == FUNC_QUANTIZE)) state_d = ST_PREP;
      end
      ST_PREP: begin
        if (hi <= lo) begin
          state_d = ST_OUT;
        end else if ((x_q <= lo) || (x_q >= hi)) begin
          state_d = ST_STEP_GO;
        end else begin
          state_d = ST_LVL_MUL;
        end
      end
      ST_LVL_MUL:  state_d = ST_LVL_GO;
      ST_LVL_GO:   state_d = ST_LVL_WAIT;
      ST_LVL_WAIT: begin
        if (!div_busy) state_d = ST_STEP_GO;
      end
      ST_STEP_GO:  state_d = ST_STEP_WAIT;
      ST_STEP_WAIT: begin
        if (!div_busy) state_d = ST_VAL_MUL;
      end
      ST_VAL_MUL:  state_d = ST_VAL_GO;
      ST_VAL_GO:   state_d = ST_VAL_WAIT;
      ST_VAL_WAIT: begin
        if (!div_busy) state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold here until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) x_q <= sample_i;
    if (state_q == ST_PREP) begin
      dist_q  <= dist_w[S-1:0];
      off_q   <= off_w[S-1:0];
      empty_q <= (hi <= lo);
      below_q <= (x_q <= lo);
      above_q <= (x_q >= hi);
      // out-of-range samples skip the level division
      if (x_q <= lo) begin
        lvl_q <= '0;
      end else begin
        lvl_q <= levels_m1[LW-1:0];
      end
    end
    if ((state_q == ST_LVL_MUL) || (state_q == ST_VAL_MUL)) prod_q <= PW'(mul_a * mul_b);
    if ((state_q == ST_LVL_WAIT) && !div_busy) lvl_q  <= div_quot[LW-1:0];
    if ((state_q == ST_STEP_WAIT) && !div_busy) step_q <= div_quot;
  end

  // ---------------------------------------------------------------------------
  // Output register; the value quotient is read straight from the divider
  // ---------------------------------------------------------------------------
  logic signed [OW-1:0] base_w;
  logic [OW-1:0]        value_w;
  logic [SW-1:0]        step_w;
  logic [LVW-1:0]       lvl_w;

  assign base_w  = OW'(lo) <<< F;
  assign value_w = base_w + OW'(div_quot);
  assign step_w  = SW'(step_q);
  assign lvl_w   = LVW'(lvl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (empty_q) begin
        value_q8_o    <= base_w[VALUE_W-1:0];
        level_index_o <= '0;
        step_q8_o     <= '0;
        range_empty_o <= 1'b1;
      end else begin
        value_q8_o    <= value_w[VALUE_W-1:0];
        level_index_o <= lvl_w[LEVEL_W-1:0];
        step_q8_o     <= step_w[STEP_W-1:0];
        range_empty_o <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `URQ_ASSERT_NOW(a_div_busy_in_wait, div_busy,
      (state_q == ST_LVL_WAIT) || (state_q == ST_STEP_WAIT) || (state_q == ST_VAL_WAIT))
  `URQ_ASSERT_NOW(a_level_in_range, (state_q == ST_LVL_WAIT) && !div_busy && !below_q && !above_q,
      div_quot < Q_W'(levels))
  `URQ_ASSERT_NEXT(a_result_not_overwritten, (state_q == ST_OUT) && out_valid_o && !out_ready_i,
      state_q == ST_OUT)
  `URQ_ASSERT_NOW(a_empty_result, out_valid_o && range_empty_o,
      (level_index_o == '0) && (step_q8_o == '0))

endmodule

`default_nettype wire
